// ===== hdl/dcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the disc collision stepper.
// No dependencies; imported by dcs_dp, dcs_ctrl and disc_collision_step_top.
package dcs_pkg;

    localparam int DISC_COUNT = 5;
    localparam int SUBSTEPS   = 5;

    localparam int DISC_W  = (DISC_COUNT > 1) ? $clog2(DISC_COUNT) : 1;
    localparam int SUB_W   = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

    localparam int POS_W   = 19;
    localparam int VEL_W   = 20;
    localparam int RAD_W   = 6;
    localparam int ARENA_W = 10;
    localparam int TIME_W  = 16;

    // contact exchange quotient is bounded by |v_i - v_j| < 2^21
    localparam int DIV_STEPS = 21;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // divide by SUBSTEPS as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_SHIFT:0] MOVE_RECIP =
        (RECIP_SHIFT + 1)'(((1 << RECIP_SHIFT) + SUBSTEPS - 1) / SUBSTEPS);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [RAD_W-1:0]        radius;
    } disc_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_READ,
        OP_DIFF,
        OP_SQ,
        OP_TEST,
        OP_ABS,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WRITE_I,
        OP_WRITE_J,
        OP_MOVE_MUL,
        OP_MOVE_RCP,
        OP_MOVE_WRITE,
        OP_OUT
    } dcs_op_t;

    typedef struct packed {
        dcs_op_t           op;
        logic [DISC_W-1:0] idx_a;
        logic [DISC_W-1:0] idx_b;
        logic              last;
    } dcs_cmd_t;

    typedef struct packed {
        logic hit;
    } dcs_stat_t;

endpackage

// ===== hdl/dcs_dp.sv =====
`timescale 1ns / 1ps
// Datapath: disc store, arena registers, pair exchange arithmetic with a
// shared-divisor restoring divider, wall/move unit and output register.
// Depends on dcs_pkg; driven by dcs_ctrl through dcs_cmd_t.
module dcs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dcs_pkg::dcs_cmd_t                     cmd,
    output dcs_pkg::dcs_stat_t                    stat,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [dcs_pkg::ARENA_W-1:0]           cfg_data,
    input  logic [2:0]                            disc_index,
    input  logic signed [dcs_pkg::POS_W-1:0]      load_pos_x,
    input  logic signed [dcs_pkg::POS_W-1:0]      load_pos_y,
    input  logic signed [dcs_pkg::VEL_W-1:0]      load_vel_x,
    input  logic signed [dcs_pkg::VEL_W-1:0]      load_vel_y,
    input  logic [dcs_pkg::RAD_W-1:0]             load_radius,
    input  logic [dcs_pkg::TIME_W-1:0]            elapsed,
    output logic [2:0]                            out_index,
    output logic signed [dcs_pkg::POS_W-1:0]      out_pos_x,
    output logic signed [dcs_pkg::POS_W-1:0]      out_pos_y,
    output logic signed [dcs_pkg::VEL_W-1:0]      out_vel_x,
    output logic signed [dcs_pkg::VEL_W-1:0]      out_vel_y,
    output logic                                  last
);
    import dcs_pkg::*;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic [ARENA_W-1:0] WIDTH_RESET  = 10'd800;
    localparam logic [ARENA_W-1:0] HEIGHT_RESET = 10'd600;

    localparam int D_W    = POS_W + 1;          // position difference
    localparam int DV_W   = VEL_W + 1;          // velocity difference
    localparam int SQ_W   = 2 * D_W;
    localparam int DSQ_W  = SQ_W + 1;
    localparam int RS_W   = RAD_W + 1;
    localparam int RSQ_W  = 2 * RS_W;
    localparam int DP_W   = DV_W + D_W;
    localparam int DOT_W  = DP_W + 1;
    localparam int MAG_W  = 15;                 // |d| < 2^15 once in contact
    localparam int MDOT_W = 36;                 // |dot| < 2^36 once in contact
    localparam int HALF   = 18;
    localparam int PP_W   = MAG_W + HALF;
    localparam int DVR_W  = 30;                 // dsq <= reach^2 < 2^30
    localparam int Q_W    = DIV_STEPS;
    localparam int N_W    = DVR_W + Q_W;
    localparam int EX_W   = Q_W + 1;
    localparam int VS_W   = VEL_W + 3;
    localparam int PS_W   = POS_W + 2;
    localparam int MV_W   = VEL_W + TIME_W;
    localparam int RP_W   = VEL_W + RECIP_SHIFT + 1;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VS_W-1:0] v);
        if (v[VS_W-1:VEL_W-1] == '0 || v[VS_W-1:VEL_W-1] == '1)
            sat_vel = v[VEL_W-1:0];
        else if (v[VS_W-1])
            sat_vel = {1'b1, {(VEL_W-1){1'b0}}};
        else
            sat_vel = {1'b0, {(VEL_W-1){1'b1}}};
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PS_W-1:0] v);
        if (v[PS_W-1:POS_W-1] == '0 || v[PS_W-1:POS_W-1] == '1)
            sat_pos = v[POS_W-1:0];
        else if (v[PS_W-1])
            sat_pos = {1'b1, {(POS_W-1){1'b0}}};
        else
            sat_pos = {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    function automatic logic signed [VEL_W-1:0] abs_vel(input logic signed [VEL_W-1:0] v);
        if (v == {1'b1, {(VEL_W-1){1'b0}}})
            abs_vel = {1'b0, {(VEL_W-1){1'b1}}};
        else if (v[VEL_W-1])
            abs_vel = -v;
        else
            abs_vel = v;
    endfunction

    // disc store
    disc_t                 mem [DISC_COUNT];
    logic [DISC_COUNT-1:0] valid_reg;
    disc_t                 rd_a_reg, rd_b_reg;
    logic                  wr_en;
    logic [DISC_W-1:0]     wr_idx;
    disc_t                 wr_data;

    logic [ARENA_W-1:0] width_reg, height_reg;
    logic [TIME_W-1:0]  t_reg;

    // pair arithmetic
    logic signed [D_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [DV_W-1:0]  dvx_reg, dvy_reg, dvx_next, dvy_next;
    logic [RS_W-1:0]         rsum_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [RSQ_W-1:0]        rsq_reg;
    logic signed [DP_W-1:0]  dotx_reg, doty_reg;
    logic [DSQ_W-1:0]        dsq_reg, dsq_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next, dot_abs;
    logic signed [D_W-1:0]   dx_abs, dy_abs;
    logic                    hit_reg;
    logic [MAG_W-1:0]        mdx_reg, mdy_reg;
    logic [MDOT_W-1:0]       mdot_reg;
    logic                    negx_reg, negy_reg;
    logic [PP_W-1:0]         plx_reg, phx_reg, ply_reg, phy_reg;
    logic [N_W:0]            numx, numy;
    logic [DVR_W-1:0]        remx_reg, remy_reg, remx_next, remy_next;
    logic [Q_W-1:0]          lowx_reg, lowy_reg, qx_reg, qy_reg;
    logic [DVR_W:0]          trialx, trialy, divisor;
    logic                    gex, gey;
    logic signed [EX_W-1:0]  exx, exy;

    // move arithmetic
    logic [VEL_W-1:0]        magx, magy, mvx_reg, mvy_reg, stx_reg, sty_reg;
    logic [MV_W-1:0]         mprodx, mprody;
    logic [RP_W-1:0]         rprodx, rprody;
    logic                    mnegx_reg, mnegy_reg;
    logic signed [VEL_W:0]   stepx, stepy;
    logic signed [PS_W-1:0]  rw, hw, ww, oxw, oyw;
    logic signed [POS_W-1:0] nx, ny;
    logic signed [VEL_W-1:0] nvx, nvy;

    assign dx_next  = $signed({rd_a_reg.pos_x[POS_W-1], rd_a_reg.pos_x})
                    - $signed({rd_b_reg.pos_x[POS_W-1], rd_b_reg.pos_x});
    assign dy_next  = $signed({rd_a_reg.pos_y[POS_W-1], rd_a_reg.pos_y})
                    - $signed({rd_b_reg.pos_y[POS_W-1], rd_b_reg.pos_y});
    assign dvx_next = $signed({rd_a_reg.vel_x[VEL_W-1], rd_a_reg.vel_x})
                    - $signed({rd_b_reg.vel_x[VEL_W-1], rd_b_reg.vel_x});
    assign dvy_next = $signed({rd_a_reg.vel_y[VEL_W-1], rd_a_reg.vel_y})
                    - $signed({rd_b_reg.vel_y[VEL_W-1], rd_b_reg.vel_y});

    assign dsq_next = DSQ_W'(sqx_reg) + DSQ_W'(sqy_reg);
    assign dot_next = DOT_W'(dotx_reg) + DOT_W'(doty_reg);
    assign dx_abs   = dx_reg[D_W-1] ? -dx_reg : dx_reg;
    assign dy_abs   = dy_reg[D_W-1] ? -dy_reg : dy_reg;
    assign dot_abs  = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;

    assign numx = {1'b0, phx_reg, {HALF{1'b0}}} + (N_W+1)'(plx_reg);
    assign numy = {1'b0, phy_reg, {HALF{1'b0}}} + (N_W+1)'(ply_reg);

    assign divisor   = {1'b0, dsq_reg[DVR_W-1:0]};
    assign trialx    = {remx_reg, lowx_reg[Q_W-1]};
    assign trialy    = {remy_reg, lowy_reg[Q_W-1]};
    assign gex       = (trialx >= divisor);
    assign gey       = (trialy >= divisor);
    assign remx_next = gex ? DVR_W'(trialx - divisor) : trialx[DVR_W-1:0];
    assign remy_next = gey ? DVR_W'(trialy - divisor) : trialy[DVR_W-1:0];

    assign exx = negx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign exy = negy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});

    assign magx   = rd_a_reg.vel_x[VEL_W-1] ? VEL_W'(-rd_a_reg.vel_x) : rd_a_reg.vel_x;
    assign magy   = rd_a_reg.vel_y[VEL_W-1] ? VEL_W'(-rd_a_reg.vel_y) : rd_a_reg.vel_y;
    assign mprodx = MV_W'(magx) * MV_W'(t_reg);
    assign mprody = MV_W'(magy) * MV_W'(t_reg);
    assign rprodx = RP_W'(mvx_reg) * RP_W'(MOVE_RECIP);
    assign rprody = RP_W'(mvy_reg) * RP_W'(MOVE_RECIP);

    assign stepx = mnegx_reg ? -$signed({1'b0, stx_reg}) : $signed({1'b0, stx_reg});
    assign stepy = mnegy_reg ? -$signed({1'b0, sty_reg}) : $signed({1'b0, sty_reg});
    assign rw    = $signed(PS_W'({rd_a_reg.radius, 8'h00}));
    assign hw    = $signed(PS_W'({height_reg, 8'h00}));
    assign ww    = $signed(PS_W'({width_reg, 8'h00}));
    assign oxw   = PS_W'(rd_a_reg.pos_x);
    assign oyw   = PS_W'(rd_a_reg.pos_y);

    // walls see the position from before the move; low wall wins
    always_comb
    begin
        nx  = sat_pos(oxw + PS_W'(stepx));
        ny  = sat_pos(oyw + PS_W'(stepy));
        nvx = rd_a_reg.vel_x;
        nvy = rd_a_reg.vel_y;
        if (oyw + rw > hw)
        begin
            nvy = -abs_vel(nvy);
            ny  = POS_W'(hw - rw);
        end
        if (oyw - rw < 0)
        begin
            nvy = abs_vel(nvy);
            ny  = POS_W'(rw);
        end
        if (oxw + rw > ww)
        begin
            nvx = -abs_vel(nvx);
            nx  = POS_W'(ww - rw);
        end
        if (oxw - rw < 0)
        begin
            nvx = abs_vel(nvx);
            nx  = POS_W'(rw);
        end
    end

    // single write port into the store
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = cmd.idx_a;
        wr_data = rd_a_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                wr_en   = (32'(disc_index) < DISC_COUNT);
                wr_idx  = DISC_W'(disc_index);
                wr_data = '{load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_radius};
            end
            OP_WRITE_I:
            begin
                wr_en         = 1'b1;
                wr_data.vel_x = sat_vel(VS_W'(rd_a_reg.vel_x) - VS_W'(exx));
                wr_data.vel_y = sat_vel(VS_W'(rd_a_reg.vel_y) - VS_W'(exy));
            end
            OP_WRITE_J:
            begin
                wr_en         = 1'b1;
                wr_idx        = cmd.idx_b;
                wr_data       = rd_b_reg;
                wr_data.vel_x = sat_vel(VS_W'(rd_b_reg.vel_x) + VS_W'(exx));
                wr_data.vel_y = sat_vel(VS_W'(rd_b_reg.vel_y) + VS_W'(exy));
            end
            OP_MOVE_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = '{nx, ny, nvx, nvy, rd_a_reg.radius};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_TICK:
                t_reg <= elapsed;
            OP_READ:
            begin
                rd_a_reg <= valid_reg[cmd.idx_a] ? mem[cmd.idx_a] : '0;
                rd_b_reg <= valid_reg[cmd.idx_b] ? mem[cmd.idx_b] : '0;
            end
            OP_DIFF:
            begin
                dx_reg   <= dx_next;
                dy_reg   <= dy_next;
                dvx_reg  <= dvx_next;
                dvy_reg  <= dvy_next;
                rsum_reg <= RS_W'(rd_a_reg.radius) + RS_W'(rd_b_reg.radius);
            end
            OP_SQ:
            begin
                sqx_reg  <= $unsigned(SQ_W'(dx_reg) * SQ_W'(dx_reg));
                sqy_reg  <= $unsigned(SQ_W'(dy_reg) * SQ_W'(dy_reg));
                rsq_reg  <= RSQ_W'(rsum_reg) * RSQ_W'(rsum_reg);
                dotx_reg <= DP_W'(dvx_reg) * DP_W'(dx_reg);
                doty_reg <= DP_W'(dvy_reg) * DP_W'(dy_reg);
            end
            OP_TEST:
            begin
                dsq_reg <= dsq_next;
                dot_reg <= dot_next;
                hit_reg <= (dsq_next != '0) && (dsq_next <= DSQ_W'({rsq_reg, 16'h0000}));
            end
            OP_ABS:
            begin
                mdx_reg  <= dx_abs[MAG_W-1:0];
                mdy_reg  <= dy_abs[MAG_W-1:0];
                mdot_reg <= dot_abs[MDOT_W-1:0];
                negx_reg <= dx_reg[D_W-1] ^ dot_reg[DOT_W-1];
                negy_reg <= dy_reg[D_W-1] ^ dot_reg[DOT_W-1];
            end
            OP_MUL:
            begin
                plx_reg <= PP_W'(mdx_reg) * PP_W'(mdot_reg[HALF-1:0]);
                phx_reg <= PP_W'(mdx_reg) * PP_W'(mdot_reg[MDOT_W-1:HALF]);
                ply_reg <= PP_W'(mdy_reg) * PP_W'(mdot_reg[HALF-1:0]);
                phy_reg <= PP_W'(mdy_reg) * PP_W'(mdot_reg[MDOT_W-1:HALF]);
            end
            OP_DIV_INIT:
            begin
                remx_reg <= numx[N_W-1:Q_W];
                lowx_reg <= numx[Q_W-1:0];
                remy_reg <= numy[N_W-1:Q_W];
                lowy_reg <= numy[Q_W-1:0];
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                remx_reg <= remx_next;
                remy_reg <= remy_next;
                lowx_reg <= {lowx_reg[Q_W-2:0], 1'b0};
                lowy_reg <= {lowy_reg[Q_W-2:0], 1'b0};
                qx_reg   <= {qx_reg[Q_W-2:0], gex};
                qy_reg   <= {qy_reg[Q_W-2:0], gey};
            end
            OP_MOVE_MUL:
            begin
                mvx_reg   <= mprodx[MV_W-1:TIME_W];
                mvy_reg   <= mprody[MV_W-1:TIME_W];
                mnegx_reg <= rd_a_reg.vel_x[VEL_W-1];
                mnegy_reg <= rd_a_reg.vel_y[VEL_W-1];
            end
            OP_MOVE_RCP:
            begin
                stx_reg <= rprodx[RECIP_SHIFT+VEL_W-1:RECIP_SHIFT];
                sty_reg <= rprody[RECIP_SHIFT+VEL_W-1:RECIP_SHIFT];
            end
            OP_OUT:
            begin
                out_index <= 3'(cmd.idx_a);
                out_pos_x <= rd_a_reg.pos_x;
                out_pos_y <= rd_a_reg.pos_y;
                out_vel_x <= rd_a_reg.vel_x;
                out_vel_y <= rd_a_reg.vel_y;
                last      <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.hit = hit_reg;

endmodule

// ===== hdl/dcs_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: walks pairs, divider steps, disc moves, substeps and results.
// Depends on dcs_pkg; commands dcs_dp.
module dcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                kind,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  dcs_pkg::dcs_stat_t  stat,
    output dcs_pkg::dcs_cmd_t   cmd
);
    import dcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREAD,
        S_PDIFF,
        S_PSQ,
        S_PTEST,
        S_PABS,
        S_PMUL,
        S_PDINIT,
        S_PDIV,
        S_PWI,
        S_PWJ,
        S_MREAD,
        S_MMUL,
        S_MRCP,
        S_MWR,
        S_OREAD,
        S_OPUT
    } state_t;

    localparam logic [DISC_W-1:0]    LAST_DISC = DISC_W'(DISC_COUNT - 1);
    localparam logic [DISC_W-1:0]    LAST_I    = DISC_W'(DISC_COUNT - 2);
    localparam logic [SUB_W-1:0]     LAST_SUB  = SUB_W'(SUBSTEPS - 1);
    localparam logic [DIV_CNT_W-1:0] LAST_DIV  = DIV_CNT_W'(DIV_STEPS - 1);

    state_t                 state_reg, state_next;
    logic [DISC_W-1:0]      pi_reg, pi_next, pj_reg, pj_next;
    logic [SUB_W-1:0]       sub_reg, sub_next;
    logic [DIV_CNT_W-1:0]   div_reg, div_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   slot_free;
    state_t                 adv_state;
    logic [DISC_W-1:0]      adv_pi, adv_pj;

    assign slot_free = !out_valid_reg || !out_stall;

    // next pair in (i, j) order, or on to the moves
    always_comb
    begin
        adv_state = S_PREAD;
        adv_pi    = pi_reg;
        adv_pj    = pj_reg + 1'b1;
        if (pj_reg == LAST_DISC)
        begin
            if (pi_reg == LAST_I)
            begin
                adv_state = S_MREAD;
                adv_pi    = '0;
                adv_pj    = DISC_W'(1);
            end
            else
            begin
                adv_pi = pi_reg + 1'b1;
                adv_pj = pi_reg + DISC_W'(2);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pi_next        = pi_reg;
        pj_next        = pj_reg;
        sub_next       = sub_reg;
        div_next       = div_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.idx_a      = pi_reg;
        cmd.idx_b      = pj_reg;
        cmd.last       = (pi_reg == LAST_DISC);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind)
                    begin
                        cmd.op     = OP_TICK;
                        pi_next    = '0;
                        pj_next    = DISC_W'(1);
                        sub_next   = '0;
                        state_next = S_PREAD;
                    end
                    else
                        cmd.op = OP_LOAD;
                end
            end
            S_PREAD:
            begin
                cmd.op     = OP_READ;
                state_next = S_PDIFF;
            end
            S_PDIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_PSQ;
            end
            S_PSQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_PTEST;
            end
            S_PTEST:
            begin
                cmd.op     = OP_TEST;
                state_next = S_PABS;
            end
            S_PABS:
            begin
                cmd.op = OP_ABS;
                if (stat.hit)
                    state_next = S_PMUL;
                else
                begin
                    state_next = adv_state;
                    pi_next    = adv_pi;
                    pj_next    = adv_pj;
                end
            end
            S_PMUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_PDINIT;
            end
            S_PDINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                div_next   = '0;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (div_reg == LAST_DIV)
                    state_next = S_PWI;
                else
                    div_next = div_reg + 1'b1;
            end
            S_PWI:
            begin
                cmd.op     = OP_WRITE_I;
                state_next = S_PWJ;
            end
            S_PWJ:
            begin
                cmd.op     = OP_WRITE_J;
                state_next = adv_state;
                pi_next    = adv_pi;
                pj_next    = adv_pj;
            end
            S_MREAD:
            begin
                cmd.op     = OP_READ;
                state_next = S_MMUL;
            end
            S_MMUL:
            begin
                cmd.op     = OP_MOVE_MUL;
                state_next = S_MRCP;
            end
            S_MRCP:
            begin
                cmd.op     = OP_MOVE_RCP;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.op = OP_MOVE_WRITE;
                if (pi_reg == LAST_DISC)
                begin
                    pi_next = '0;
                    if (sub_reg == LAST_SUB)
                        state_next = S_OREAD;
                    else
                    begin
                        sub_next   = sub_reg + 1'b1;
                        pj_next    = DISC_W'(1);
                        state_next = S_PREAD;
                    end
                end
                else
                begin
                    pi_next    = pi_reg + 1'b1;
                    state_next = S_MREAD;
                end
            end
            S_OREAD:
            begin
                cmd.op     = OP_READ;
                state_next = S_OPUT;
            end
            S_OPUT:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    if (pi_reg == LAST_DISC)
                        state_next = S_IDLE;
                    else
                    begin
                        pi_next    = pi_reg + 1'b1;
                        state_next = S_OREAD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pi_reg        <= '0;
            pj_reg        <= '0;
            sub_reg       <= '0;
            div_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pi_reg        <= pi_next;
            pj_reg        <= pj_next;
            sub_reg       <= sub_next;
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> slot_free)
        else $error("result loaded over an untaken one");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PDIV || state_reg == S_PWI || state_reg == S_PWJ)
        |-> pj_reg > pi_reg)
        else $error("pair indices out of order");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PDIV |-> div_reg <= LAST_DIV)
        else $error("divider ran past its step count");

    a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPUT && slot_free && pi_reg == LAST_DISC)
        |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("tick did not finish on the last result");

endmodule

// ===== hdl/disc_collision_step_top.sv =====
`timescale 1ns / 1ps
// Top level of the disc collision stepper: sequencer plus datapath.
// Depends on dcs_pkg, dcs_ctrl and dcs_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid / in_stall    | kind, disc_index, load_*, elapsed
//   out     | out_valid / out_stall  | out_index, out_pos_*, out_vel_*, last
//   cfg     | cfg_write              | cfg_index, cfg_data
//
// A load item is written while idle and the block stays idle. A tick, in each substep,
// walks every pair, runs the 21-step shared divider for each touching pair and then
// moves every disc; after the last substep it puts out one result per disc.
// Reset: discs read as zero, arena 800 x 600; no clearing pass.
// in_stall is high while a tick runs; out_stall holds the result phase.
module disc_collision_step_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [2:0]                        disc_index,
    input  logic signed [dcs_pkg::POS_W-1:0]  load_pos_x,
    input  logic signed [dcs_pkg::POS_W-1:0]  load_pos_y,
    input  logic signed [dcs_pkg::VEL_W-1:0]  load_vel_x,
    input  logic signed [dcs_pkg::VEL_W-1:0]  load_vel_y,
    input  logic [dcs_pkg::RAD_W-1:0]         load_radius,
    input  logic [dcs_pkg::TIME_W-1:0]        elapsed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        out_index,
    output logic signed [dcs_pkg::POS_W-1:0]  out_pos_x,
    output logic signed [dcs_pkg::POS_W-1:0]  out_pos_y,
    output logic signed [dcs_pkg::VEL_W-1:0]  out_vel_x,
    output logic signed [dcs_pkg::VEL_W-1:0]  out_vel_y,
    output logic                              last,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [dcs_pkg::ARENA_W-1:0]       cfg_data
);
    import dcs_pkg::*;

    dcs_cmd_t  cmd;
    dcs_stat_t stat;

    dcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .disc_index  (disc_index),
        .load_pos_x  (load_pos_x),
        .load_pos_y  (load_pos_y),
        .load_vel_x  (load_vel_x),
        .load_vel_y  (load_vel_y),
        .load_radius (load_radius),
        .elapsed     (elapsed),
        .out_index   (out_index),
        .out_pos_x   (out_pos_x),
        .out_pos_y   (out_pos_y),
        .out_vel_x   (out_vel_x),
        .out_vel_y   (out_vel_y),
        .last        (last)
    );

endmodule

// ===== bench/tb_disc_collision_step_top.sv =====
`timescale 1ns / 1ps
// Testbench for disc_collision_step_top: random and directed load/tick items,
// checked against a fixed-point disc predictor held in a small scoreboard class.
// Depends on dcs_pkg and the disc_collision_step_top RTL.
module tb_disc_collision_step_top;
    import dcs_pkg::*;

    localparam bit KIND_LOAD = 1'b0;
    localparam bit KIND_TICK = 1'b1;
    localparam bit REG_ARENA_WIDTH  = 1'b0;
    localparam bit REG_ARENA_HEIGHT = 1'b1;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 30;

    typedef struct {
        bit                      kind;
        bit [2:0]                idx;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        bit [RAD_W-1:0]          r;
        bit [TIME_W-1:0]         t;
    } disc_cmd_item_t;

    typedef struct {
        bit [2:0]                idx;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        bit                      lst;
    } disc_report_t;

    class disc_scoreboard;
        longint arena_w, arena_h;
        longint pos_x[DISC_COUNT], pos_y[DISC_COUNT];
        longint vel_x[DISC_COUNT], vel_y[DISC_COUNT], rad[DISC_COUNT];
        disc_report_t pending_reports[$];
        int errors, ticks, reports, contacts;

        function new();
            arena_w = 800;
            arena_h = 600;
            foreach (pos_x[i])
            begin
                pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0; rad[i] = 0;
            end
        endfunction

        function longint clip(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function longint mag(longint v);
            return clip(v < 0 ? -v : v, VEL_W);
        endfunction

        function void write_reg(bit index, bit [ARENA_W-1:0] value);
            if (index == REG_ARENA_WIDTH)
                arena_w = value;
            else
                arena_h = value;
        endfunction

        function void exchange_contacts();
            longint dx, dy, dsq, reach, dot, ex, ey;
            for (int i = 0; i < DISC_COUNT; i++)
                for (int j = i + 1; j < DISC_COUNT; j++)
                begin
                    dx = pos_x[i] - pos_x[j];
                    dy = pos_y[i] - pos_y[j];
                    dsq = dx * dx + dy * dy;
                    reach = (rad[i] + rad[j]) * 256;
                    // coincident centres are skipped
                    if (dsq == 0 || dsq > reach * reach)
                        continue;
                    contacts++;
                    dot = (vel_x[i] - vel_x[j]) * dx + (vel_y[i] - vel_y[j]) * dy;
                    ex = (dx * dot) / dsq;
                    ey = (dy * dot) / dsq;
                    vel_x[i] = clip(vel_x[i] - ex, VEL_W);
                    vel_y[i] = clip(vel_y[i] - ey, VEL_W);
                    vel_x[j] = clip(vel_x[j] + ex, VEL_W);
                    vel_y[j] = clip(vel_y[j] + ey, VEL_W);
                end
        endfunction

        function void move_all(longint t);
            longint w, h, r, ox, oy, nx, ny, den;
            den = longint'(SUBSTEPS) * 65536;
            w = arena_w * 256;
            h = arena_h * 256;
            for (int i = 0; i < DISC_COUNT; i++)
            begin
                r = rad[i] * 256;
                ox = pos_x[i];
                oy = pos_y[i];
                nx = clip(ox + (vel_x[i] * t) / den, POS_W);
                ny = clip(oy + (vel_y[i] * t) / den, POS_W);
                // walls judge the old position; the low wall wins
                if (oy + r > h)
                begin
                    vel_y[i] = -mag(vel_y[i]); ny = h - r;
                end
                if (oy - r < 0)
                begin
                    vel_y[i] = mag(vel_y[i]); ny = r;
                end
                if (ox + r > w)
                begin
                    vel_x[i] = -mag(vel_x[i]); nx = w - r;
                end
                if (ox - r < 0)
                begin
                    vel_x[i] = mag(vel_x[i]); nx = r;
                end
                pos_x[i] = nx;
                pos_y[i] = ny;
            end
        endfunction

        function void note_input(disc_cmd_item_t it);
            disc_report_t rep;
            if (it.kind == KIND_LOAD)
            begin
                if (it.idx < DISC_COUNT)
                begin
                    pos_x[it.idx] = it.px; pos_y[it.idx] = it.py;
                    vel_x[it.idx] = it.vx; vel_y[it.idx] = it.vy;
                    rad[it.idx] = it.r;
                end
                return;
            end
            ticks++;
            for (int k = 0; k < SUBSTEPS; k++)
            begin
                exchange_contacts();
                move_all(longint'(it.t));
            end
            for (int i = 0; i < DISC_COUNT; i++)
            begin
                rep.idx = i;
                rep.px = pos_x[i]; rep.py = pos_y[i];
                rep.vx = vel_x[i]; rep.vy = vel_y[i];
                rep.lst = (i == DISC_COUNT - 1);
                pending_reports.push_back(rep);
            end
        endfunction

        function void cmp(string name, longint e, longint a);
            if (e != a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(disc_report_t got);
            disc_report_t e;
            reports++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual index %0d",
                         $time, got.idx);
                return;
            end
            e = pending_reports.pop_front();
            cmp("out_index", e.idx, got.idx);
            cmp("out_pos_x", e.px, got.px);
            cmp("out_pos_y", e.py, got.py);
            cmp("out_vel_x", e.vx, got.vx);
            cmp("out_vel_y", e.vy, got.vy);
            cmp("last", e.lst, got.lst);
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, kind;
    logic [2:0] disc_index;
    logic signed [POS_W-1:0] load_pos_x, load_pos_y;
    logic signed [VEL_W-1:0] load_vel_x, load_vel_y;
    logic [RAD_W-1:0] load_radius;
    logic [TIME_W-1:0] elapsed;
    logic out_valid, out_stall;
    logic [2:0] out_index;
    logic signed [POS_W-1:0] out_pos_x, out_pos_y;
    logic signed [VEL_W-1:0] out_vel_x, out_vel_y;
    logic last;
    logic cfg_write, cfg_index;
    logic [ARENA_W-1:0] cfg_data;

    disc_scoreboard sb;
    int send_idle_pct, recv_stall_pct;
    int items_sent, cycles;
    bit hold_go, hold_active;

    disc_collision_step_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .disc_index(disc_index),
        .load_pos_x(load_pos_x), .load_pos_y(load_pos_y),
        .load_vel_x(load_vel_x), .load_vel_y(load_vel_y),
        .load_radius(load_radius), .elapsed(elapsed),
        .out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
        .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .last(last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);

    // long receiver hold-off so the block backs up into its input
    always
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (900) @(posedge clk);
        hold_active <= 1'b0;
        hold_go = 1'b0;
    end

    always @(posedge clk)
    begin
        disc_report_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.idx = out_index;
            got.px = out_pos_x; got.py = out_pos_y;
            got.vx = out_vel_x; got.vy = out_vel_y;
            got.lst = last;
            sb.check_result(got);
        end
    end

    task automatic send_item(disc_cmd_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        disc_index <= it.idx;
        load_pos_x <= it.px; load_pos_y <= it.py;
        load_vel_x <= it.vx; load_vel_y <= it.vy;
        load_radius <= it.r;
        elapsed <= it.t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        if (it.kind == KIND_TICK || it.idx < DISC_COUNT)
            items_sent++;
    endtask

    task automatic load_disc(int idx, longint px, longint py, longint vx, longint vy, int r);
        disc_cmd_item_t it;
        it.kind = KIND_LOAD; it.idx = idx;
        it.px = px; it.py = py; it.vx = vx; it.vy = vy; it.r = r; it.t = $urandom;
        send_item(it);
    endtask

    task automatic tick(int t);
        disc_cmd_item_t it;
        it.kind = KIND_TICK; it.t = t;
        it.idx = $urandom; it.px = $urandom; it.py = $urandom;
        it.vx = $urandom; it.vy = $urandom; it.r = $urandom;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_arena(bit index, int value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= ARENA_W'(value);
        @(posedge clk);
        sb.write_reg(index, ARENA_W'(value));
        cfg_write <= 1'b0;
    endtask

    // mostly clustered discs inside the arena, some fully random loads, so that contacts and wall hits are common
    task automatic random_scene();
        int w, h, cx, cy, r, idx;
        longint vx, vy, px, py;
        w = sb.arena_w;
        h = sb.arena_h;
        cx = $urandom_range(32, w - 32);
        cy = $urandom_range(32, h - 32);
        for (int n = 0; n < DISC_COUNT; n++)
        begin
            if ($urandom_range(99) < 85)
            begin
                idx = n;
                r = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 40);
                px = longint'(cx) * 256 + $signed($urandom_range(0, 16000)) - 8000;
                py = longint'(cy) * 256 + $signed($urandom_range(0, 16000)) - 8000;
                vx = $signed($urandom_range(0, 120000)) - 60000;
                vy = $signed($urandom_range(0, 120000)) - 60000;
            end
            else
            begin
                idx = $urandom_range(7);
                r = $urandom_range(63);
                px = $signed(19'($urandom)); py = $signed(19'($urandom));
                vx = $signed(20'($urandom)); vy = $signed(20'($urandom));
            end
            load_disc(idx, px, py, vx, vy, r);
        end
        repeat ($urandom_range(1, 3))
            tick($urandom_range(0, 65535));
    endtask

    task automatic run_phase(int send_idle, int recv_stall, int w, int h, bit pressure);
        int goal;
        wait_idle();
        write_arena(REG_ARENA_WIDTH, w);
        write_arena(REG_ARENA_HEIGHT, h);
        send_idle_pct = send_idle;
        recv_stall_pct = recv_stall;
        if (pressure)
            hold_go = 1'b1;
        goal = items_sent + ITEMS_PER_PHASE;
        while (items_sent < goal)
            random_scene();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0; kind = 1'b0; disc_index = '0;
        load_pos_x = '0; load_pos_y = '0; load_vel_x = '0; load_vel_y = '0;
        load_radius = '0; elapsed = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        items_sent = 0; cycles = 0;
        hold_go = 1'b0; hold_active = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: head-on contact, coincident centres, wall and extremes
        load_disc(0, 100 * 256, 100 * 256, 25600, 0, 10);
        load_disc(1, 115 * 256, 102 * 256, -25600, 3000, 10);
        load_disc(2, 300 * 256, 300 * 256, 5000, -5000, 5);
        load_disc(3, 300 * 256, 300 * 256, -5000, 5000, 5);
        load_disc(4, 795 * 256, 590 * 256, 524287, 524287, 20);
        tick(65535);
        load_disc(7, 1, 2, 3, 4, 5);
        load_disc(5, -1, -1, -1, -1, 63);
        load_disc(2, -262144, -262144, -524288, -524288, 63);
        load_disc(3, 262143, 262143, 524287, 524287, 0);
        tick(0);
        tick(1);
        load_disc(0, 200 * 256, 200 * 256, -524288, 524287, 63);
        load_disc(1, 260 * 256, 200 * 256, 524287, -524288, 63);
        tick(65535);
        tick(32768);
        while (items_sent < ITEMS_PER_PHASE)
            random_scene();

        run_phase(87, 0, 1023, 1023, 1'b0);
        run_phase(0, 87, 64, 64, 1'b1);
        run_phase(87, 87, 300, 700, 1'b0);
        run_phase(0, 0, 1023, 64, 1'b1);
        run_phase(11, 11, 64, 1023, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d accepted items, %0d ticks, %0d disc results, %0d contacts,",
                 items_sent, sb.ticks, sb.reports, sb.contacts);
        $display("over six arena settings and several idle/stall mixes.");
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.errors, sb.pending_reports.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
